// ===== rtl/bilinear_area_table_interpolator_unit_macros.svh =====
// Assertion macros for the checker file of the interpolator unit
`ifndef BILINEAR_AREA_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define BILINEAR_AREA_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BATI_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bati check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BATI_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bati check failed");

`endif

// ===== rtl/bati_pkg.sv =====
// Shared types and constants of the bilinear area table interpolator
package bati_pkg;

    localparam int ANGLE_W     = 18;
    localparam int ANGLE_FRAC  = 16;
    localparam int SCALE_W     = 24;
    localparam int POINTS_W    = 7;
    localparam int ENTRY_IDX_W = 6;
    localparam int AREA_PORT_W = 16;
    localparam int FRAC_BITS   = 12;
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int NUM_BANKS   = 4;
    localparam int BANK_SEL_W  = 2;

    // Angle after abs/sign extension, and angle minus grid minimum
    localparam int ANG_EXT_W = ANGLE_W + 1;
    localparam int DIFF_W    = ANGLE_W + 2;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

    // Configuration reset values
    localparam logic signed [ANGLE_W-1:0] MIN_RST    = '0;
    localparam logic [SCALE_W-1:0]        SCALE_RST  = SCALE_W'(4096);
    localparam logic [POINTS_W-1:0]       POINTS_RST = POINTS_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_MIN    = 3'd0,
        CFG_YAW_MIN      = 3'd1,
        CFG_PITCH_SCALE  = 3'd2,
        CFG_YAW_SCALE    = 3'd3,
        CFG_PITCH_POINTS = 3'd4,
        CFG_YAW_POINTS   = 3'd5
    } cfg_reg_e;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_e;

    // Per-axis cell position handed from the mapping stages to the blend
    typedef struct packed {
        logic                 parity;
        logic                 at_last;
        logic                 clamped;
        logic [FRAC_BITS-1:0] frac;
    } axis_pos_t;

    // Load enables of the seven pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
        logic ld7;
    } stage_ld_t;

endpackage

// ===== rtl/bati_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bati_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bati_axis.sv =====
// Angle to cell position mapping for one grid axis, three pipeline stages
module bati_axis import bati_pkg::*; #(
    parameter int POINTS_MAX = 64,
    localparam int IDX_W = (POINTS_MAX > 2) ? $clog2(POINTS_MAX) : 1,
    localparam int ROW_W = (((POINTS_MAX + 1) / 2) > 1) ? $clog2((POINTS_MAX + 1) / 2) : 1
) (
    input  logic                        clk,
    input  stage_ld_t                   ld,
    input  logic signed [ANG_EXT_W-1:0] angle,
    input  logic signed [ANGLE_W-1:0]   min_val,
    input  logic [SCALE_W-1:0]          scale,
    input  logic [POINTS_W-1:0]         points,
    output axis_pos_t                   pos,
    output logic [ROW_W-1:0]            row_even,
    output logic [ROW_W-1:0]            row_odd
);

    localparam int NP_W    = $clog2(POINTS_MAX + 1);
    localparam int MAG_W   = DIFF_W - 1;
    localparam int PROD_W  = MAG_W + SCALE_W;
    localparam int RAW_W   = PROD_W - ANGLE_FRAC;
    localparam int LIM_W   = IDX_W + FRAC_BITS;
    localparam int NXT_W   = IDX_W + 1;

    // Stage 1: offset by grid minimum, clamp point count
    logic signed [DIFF_W-1:0] diff_next, diff_reg;
    logic [NP_W-1:0]          np_next, np1_reg;

    assign diff_next = DIFF_W'(angle) - DIFF_W'(min_val);

    always_comb
    begin
        if (points < POINTS_W'(2))
        begin
            np_next = NP_W'(2);
        end
        else if (int'(points) > POINTS_MAX)
        begin
            np_next = NP_W'(POINTS_MAX);
        end
        else
        begin
            np_next = NP_W'(points);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld1)
        begin
            diff_reg <= diff_next;
            np1_reg  <= np_next;
        end
    end

    // Stage 2: scale the offset into a Q.12 cell position
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw_next, raw_reg;
    logic              neg_reg;
    logic [NP_W-1:0]   np2_reg;

    assign mag      = diff_reg[MAG_W-1:0];
    assign prod     = PROD_W'(mag) * PROD_W'(scale);
    assign raw_next = prod[PROD_W-1:ANGLE_FRAC];

    always_ff @(posedge clk)
    begin
        if (ld.ld2)
        begin
            raw_reg <= raw_next;
            neg_reg <= diff_reg[DIFF_W-1];
            np2_reg <= np1_reg;
        end
    end

    // Stage 3: clamp to the grid and flag the clamp
    logic [IDX_W-1:0] last_next, last_reg;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] pos_next, pos_reg;
    logic             clamped_next, clamped_reg;

    assign last_next = IDX_W'(np2_reg - NP_W'(1));
    assign limit     = {last_next, FRAC_BITS'(0)};

    always_comb
    begin
        if (neg_reg)
        begin
            pos_next     = '0;
            clamped_next = 1'b1;
        end
        else if (raw_reg > RAW_W'(limit))
        begin
            pos_next     = limit;
            clamped_next = 1'b1;
        end
        else
        begin
            pos_next     = LIM_W'(raw_reg);
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld3)
        begin
            pos_reg     <= pos_next;
            clamped_reg <= clamped_next;
            last_reg    <= last_next;
        end
    end

    // Neighbor rows per parity bank; the upper neighbor folds onto the lower at the edge
    logic [IDX_W-1:0] idx0;
    logic [NXT_W-1:0] idx1;
    logic [ROW_W-1:0] own_row, other_row;

    assign idx0      = pos_reg[LIM_W-1:FRAC_BITS];
    assign idx1      = NXT_W'(idx0) + NXT_W'(1);
    assign own_row   = ROW_W'(idx0 >> 1);
    assign other_row = pos.at_last ? own_row : ROW_W'(idx1 >> 1);

    assign pos.parity  = idx0[0];
    assign pos.at_last = (idx0 == last_reg);
    assign pos.clamped = clamped_reg;
    assign pos.frac    = pos_reg[FRAC_BITS-1:0];

    assign row_even = pos.parity ? other_row : own_row;
    assign row_odd  = pos.parity ? own_row : other_row;

endmodule

// ===== rtl/bati_blend.sv =====
// Bilinear blend of the four neighbor words, three pipeline stages
module bati_blend import bati_pkg::*; #(
    parameter int AREA_BITS = 16
) (
    input  logic                   clk,
    input  stage_ld_t              ld,
    input  logic [AREA_BITS-1:0]   bank_rdata [NUM_BANKS],
    input  axis_pos_t              p_pos,
    input  axis_pos_t              y_pos,
    output logic [AREA_PORT_W-1:0] area_out,
    output logic                   out_of_range
);

    localparam int T_W = AREA_BITS + WGT_W;
    localparam int U_W = T_W + WGT_W;
    localparam int S_W = U_W + 2;
    localparam logic [S_W-1:0] ROUND_HALF = S_W'(1) << (2 * FRAC_BITS - 1);

    // Stage 5: pick neighbors by bank parity, weight along yaw
    logic [BANK_SEL_W-1:0] sel00, sel01, sel10, sel11;
    logic [AREA_BITS-1:0]  nb [NUM_BANKS];
    logic [WGT_W-1:0]      wy0, wy1, wp0, wp1;
    logic [T_W-1:0]        t_next [NUM_BANKS];
    logic [T_W-1:0]        t_reg  [NUM_BANKS];
    logic [WGT_W-1:0]      wp0_reg, wp1_reg;
    logic                  oor5_reg;

    assign sel00 = {p_pos.parity, y_pos.parity};
    assign sel01 = {p_pos.parity, ~y_pos.parity};
    assign sel10 = {~p_pos.parity, y_pos.parity};
    assign sel11 = {~p_pos.parity, ~y_pos.parity};

    // Drop a folded neighbor; its weight is zero anyway
    assign nb[0] = bank_rdata[sel00];
    assign nb[1] = y_pos.at_last ? '0 : bank_rdata[sel01];
    assign nb[2] = p_pos.at_last ? '0 : bank_rdata[sel10];
    assign nb[3] = (p_pos.at_last || y_pos.at_last) ? '0 : bank_rdata[sel11];

    assign wy1 = WGT_W'(y_pos.frac);
    assign wy0 = WGT_ONE - wy1;
    assign wp1 = WGT_W'(p_pos.frac);
    assign wp0 = WGT_ONE - wp1;

    assign t_next[0] = T_W'(nb[0]) * T_W'(wy0);
    assign t_next[1] = T_W'(nb[1]) * T_W'(wy1);
    assign t_next[2] = T_W'(nb[2]) * T_W'(wy0);
    assign t_next[3] = T_W'(nb[3]) * T_W'(wy1);

    always_ff @(posedge clk)
    begin
        if (ld.ld5)
        begin
            t_reg    <= t_next;
            wp0_reg  <= wp0;
            wp1_reg  <= wp1;
            oor5_reg <= p_pos.clamped | y_pos.clamped;
        end
    end

    // Stage 6: weight along pitch
    logic [U_W-1:0] u_next [NUM_BANKS];
    logic [U_W-1:0] u_reg  [NUM_BANKS];
    logic           oor6_reg;

    assign u_next[0] = U_W'(t_reg[0]) * U_W'(wp0_reg);
    assign u_next[1] = U_W'(t_reg[1]) * U_W'(wp0_reg);
    assign u_next[2] = U_W'(t_reg[2]) * U_W'(wp1_reg);
    assign u_next[3] = U_W'(t_reg[3]) * U_W'(wp1_reg);

    always_ff @(posedge clk)
    begin
        if (ld.ld6)
        begin
            u_reg    <= u_next;
            oor6_reg <= oor5_reg;
        end
    end

    // Stage 7: sum, round half up, drop the weight fraction
    logic [S_W-1:0]         sum;
    logic [AREA_PORT_W-1:0] area_next, area_reg;
    logic                   oor_reg;

    assign sum = S_W'(u_reg[0]) + S_W'(u_reg[1]) + S_W'(u_reg[2]) + S_W'(u_reg[3])
               + ROUND_HALF;
    assign area_next = AREA_PORT_W'(sum[S_W-1:2*FRAC_BITS]);

    always_ff @(posedge clk)
    begin
        if (ld.ld7)
        begin
            area_reg <= area_next;
            oor_reg  <= oor6_reg;
        end
    end

    assign area_out     = area_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== rtl/bilinear_area_table_interpolator_unit.sv =====
// Top level: config registers, pipeline control and banked area table
//
//  channel  | direction | word                                       | taken when
//  ---------+-----------+--------------------------------------------+----------------------
//  in       | to block  | func, entry indices/area, query angles     | in_valid & in_ready
//  out      | from block| area_out, out_of_range (queries only)      | out_valid & out_ready
//  cfg      | to block  | cfg_index, cfg_data                        | cfg_valid & cfg_ready
//
//  One word per cycle in and out while the output is not stalled.
//  Stages: offset, scale multiply, clamp, table read (four parity banks, one read each),
//  yaw weight multiply, pitch weight multiply, sum and round into the output register.
//  A table write lands at the table-read stage and yields no output word.
//  Each stage holds only while full and its successor holds, so bubbles collapse and
//  in_ready falls only once the whole pipeline is full behind a stalled output.
//  Reset clears valid bits and loads config registers with their reset values; the table is not cleared.
module bilinear_area_table_interpolator_unit import bati_pkg::*; #(
    parameter int PITCH_POINTS_MAX = 64,
    parameter int YAW_POINTS_MAX   = 64,
    parameter int AREA_BITS        = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [ENTRY_IDX_W-1:0]    entry_pitch_index,
    input  logic [ENTRY_IDX_W-1:0]    entry_yaw_index,
    input  logic [AREA_PORT_W-1:0]    entry_area,
    input  logic signed [ANGLE_W-1:0] query_pitch,
    input  logic signed [ANGLE_W-1:0] query_yaw,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [AREA_PORT_W-1:0]    area_out,
    output logic                      out_of_range,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int P_ROWS     = (PITCH_POINTS_MAX + 1) / 2;
    localparam int Y_ROWS     = (YAW_POINTS_MAX + 1) / 2;
    localparam int P_ROW_W    = (P_ROWS > 1) ? $clog2(P_ROWS) : 1;
    localparam int Y_ROW_W    = (Y_ROWS > 1) ? $clog2(Y_ROWS) : 1;
    localparam int BANK_DEPTH = P_ROWS * Y_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Configuration registers
    logic signed [ANGLE_W-1:0] pitch_min_reg, yaw_min_reg;
    logic [SCALE_W-1:0]        pitch_scale_reg, yaw_scale_reg;
    logic [POINTS_W-1:0]       pitch_points_reg, yaw_points_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_min_reg    <= MIN_RST;
            yaw_min_reg      <= MIN_RST;
            pitch_scale_reg  <= SCALE_RST;
            yaw_scale_reg    <= SCALE_RST;
            pitch_points_reg <= POINTS_RST;
            yaw_points_reg   <= POINTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PITCH_MIN:    pitch_min_reg    <= cfg_data[ANGLE_W-1:0];
                CFG_YAW_MIN:      yaw_min_reg      <= cfg_data[ANGLE_W-1:0];
                CFG_PITCH_SCALE:  pitch_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_YAW_SCALE:    yaw_scale_reg    <= cfg_data[SCALE_W-1:0];
                CFG_PITCH_POINTS: pitch_points_reg <= cfg_data[POINTS_W-1:0];
                CFG_YAW_POINTS:   yaw_points_reg   <= cfg_data[POINTS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline valid bits and load enables
    logic      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    stage_ld_t ld;

    always_comb
    begin
        ld.ld7 = !v7_reg || out_ready;
        ld.ld6 = !v6_reg || ld.ld7;
        ld.ld5 = !v5_reg || ld.ld6;
        ld.ld4 = !v4_reg || ld.ld5;
        ld.ld3 = !v3_reg || ld.ld4;
        ld.ld2 = !v2_reg || ld.ld3;
        ld.ld1 = !v1_reg || ld.ld2;
    end

    assign in_ready  = ld.ld1;
    assign out_valid = v7_reg;

    // Write words retire at the table stage
    func_e s1_func_reg, s2_func_reg, s3_func_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (ld.ld1) v1_reg <= in_valid;
            if (ld.ld2) v2_reg <= v1_reg;
            if (ld.ld3) v3_reg <= v2_reg;
            if (ld.ld4) v4_reg <= v3_reg && (s3_func_reg == FUNC_QUERY);
            if (ld.ld5) v5_reg <= v4_reg;
            if (ld.ld6) v6_reg <= v5_reg;
            if (ld.ld7) v7_reg <= v6_reg;
        end
    end

    // Carry write fields alongside the angle mapping
    logic [ENTRY_IDX_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg;
    logic [ENTRY_IDX_W-1:0] s1_col_reg, s2_col_reg, s3_col_reg;
    logic [AREA_BITS-1:0]   s1_data_reg, s2_data_reg, s3_data_reg;

    always_ff @(posedge clk)
    begin
        if (ld.ld1)
        begin
            s1_func_reg <= func_e'(func);
            s1_row_reg  <= entry_pitch_index;
            s1_col_reg  <= entry_yaw_index;
            s1_data_reg <= AREA_BITS'(entry_area);
        end
        if (ld.ld2)
        begin
            s2_func_reg <= s1_func_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_data_reg <= s1_data_reg;
        end
        if (ld.ld3)
        begin
            s3_func_reg <= s2_func_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_data_reg <= s2_data_reg;
        end
    end

    // Angle mapping, yaw folded to its absolute value
    logic signed [ANG_EXT_W-1:0] pitch_ext, yaw_ext, yaw_abs;
    axis_pos_t                   p_pos, y_pos;
    logic [P_ROW_W-1:0]          p_row_even, p_row_odd;
    logic [Y_ROW_W-1:0]          y_row_even, y_row_odd;

    assign pitch_ext = ANG_EXT_W'(query_pitch);
    assign yaw_ext   = ANG_EXT_W'(query_yaw);
    assign yaw_abs   = yaw_ext[ANG_EXT_W-1] ? -yaw_ext : yaw_ext;

    bati_axis #(
        .POINTS_MAX (PITCH_POINTS_MAX)
    ) u_pitch_axis (
        .clk      (clk),
        .ld       (ld),
        .angle    (pitch_ext),
        .min_val  (pitch_min_reg),
        .scale    (pitch_scale_reg),
        .points   (pitch_points_reg),
        .pos      (p_pos),
        .row_even (p_row_even),
        .row_odd  (p_row_odd)
    );

    bati_axis #(
        .POINTS_MAX (YAW_POINTS_MAX)
    ) u_yaw_axis (
        .clk      (clk),
        .ld       (ld),
        .angle    (yaw_abs),
        .min_val  (yaw_min_reg),
        .scale    (yaw_scale_reg),
        .points   (yaw_points_reg),
        .pos      (y_pos),
        .row_even (y_row_even),
        .row_odd  (y_row_odd)
    );

    // Table stage: one write or four neighbor reads, banked by index parity
    logic                  wr_ok;
    logic [BANK_SEL_W-1:0] wr_bank;
    logic [BANK_AW-1:0]    wr_addr;
    logic                  bank_we    [NUM_BANKS];
    logic [BANK_AW-1:0]    bank_raddr [NUM_BANKS];
    logic [AREA_BITS-1:0]  bank_rdata [NUM_BANKS];
    axis_pos_t             s4_p_pos_reg, s4_y_pos_reg;

    assign wr_ok   = (int'(s3_row_reg) < PITCH_POINTS_MAX) && (int'(s3_col_reg) < YAW_POINTS_MAX);
    assign wr_bank = {s3_row_reg[0], s3_col_reg[0]};
    assign wr_addr = BANK_AW'(int'(s3_row_reg >> 1) * Y_ROWS + int'(s3_col_reg >> 1));

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic [BANK_SEL_W-1:0] SEL = BANK_SEL_W'(b);

        logic [P_ROW_W-1:0] prow;
        logic [Y_ROW_W-1:0] yrow;

        assign prow = SEL[1] ? p_row_odd : p_row_even;
        assign yrow = SEL[0] ? y_row_odd : y_row_even;
        assign bank_raddr[b] = BANK_AW'(int'(prow) * Y_ROWS + int'(yrow));
        assign bank_we[b] = ld.ld4 && v3_reg && (s3_func_reg == FUNC_WRITE) && wr_ok
                          && (wr_bank == SEL);

        bati_ram #(
            .WIDTH (AREA_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (wr_addr),
            .wdata (s3_data_reg),
            .re    (ld.ld4),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld4)
        begin
            s4_p_pos_reg <= p_pos;
            s4_y_pos_reg <= y_pos;
        end
    end

    // Blend and output register
    bati_blend #(
        .AREA_BITS (AREA_BITS)
    ) u_blend (
        .clk          (clk),
        .ld           (ld),
        .bank_rdata   (bank_rdata),
        .p_pos        (s4_p_pos_reg),
        .y_pos        (s4_y_pos_reg),
        .area_out     (area_out),
        .out_of_range (out_of_range)
    );

endmodule

// ===== rtl/bati_checker.sv =====
// Port-level checks of the interpolator unit and their bind
`include "bilinear_area_table_interpolator_unit_macros.svh"

module bati_checker import bati_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [AREA_PORT_W-1:0] area_out,
    input logic                   out_of_range,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // Hold a stalled output word
    `BATI_ASSERT_NXT(a_out_valid_hold, out_valid && !out_ready, out_valid)
    `BATI_ASSERT_NXT(a_out_word_hold, out_valid && !out_ready, $stable(area_out) && $stable(out_of_range))

    // An empty or draining output stage never blocks the input
    `BATI_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
    `BATI_ASSERT_IMP(a_ready_when_drain, out_ready, in_ready)

    // Config writes are always taken
    `BATI_ASSERT_IMP(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind bilinear_area_table_interpolator_unit bati_checker u_bati_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .area_out     (area_out),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
